// ===== rtl/core/dol_pkg.sv =====
// ----------------------------------------------------------------------------
// dol_pkg
// Shared types and constants for the DHCP option locator.
// ----------------------------------------------------------------------------
package dol_pkg;

  // Default area sizes in bytes
  localparam int unsigned OPTIONS_AREA_BYTES_DEF = 308;
  localparam int unsigned FILE_AREA_BYTES_DEF    = 128;
  localparam int unsigned SNAME_AREA_BYTES_DEF   = 64;

  // Position widths: byte position wraps at 9 bits, option end at 10 bits
  localparam int unsigned POS_W = 9;
  localparam int unsigned NOP_W = 10;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Option codes
  localparam logic [7:0] CODE_PAD      = 8'd0;
  localparam logic [7:0] CODE_OVERLOAD = 8'd52;
  localparam logic [7:0] CODE_END      = 8'd255;

  localparam logic [7:0] TARGET_RESET  = 8'd53;

  // Areas
  localparam logic [1:0] AREA_OPTIONS = 2'd0;
  localparam logic [1:0] AREA_FILE    = 2'd1;
  localparam logic [1:0] AREA_SNAME   = 2'd2;

  // Result status
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_OVER = 2'd3
  } dol_phase_t;

  // One classified byte
  typedef struct packed {
    logic [7:0] opt_byte;
    logic [1:0] area;
    logic       packet_start;
    logic       is_target;
    logic       is_pad;
    logic       is_end;
    logic       is_overload;
  } dol_item_t;

  // Handshake between queue and its neighbors
  typedef struct packed {
    logic      valid;
    dol_item_t item;
  } dol_req_t;

endpackage

// ===== rtl/core/dhcp_option_locator.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_locator
// Scans DHCP option, file and sname bytes and locates one option code.
// ----------------------------------------------------------------------------
// Feed the packet one byte per request: options area first, then file, then
// sname, with in_packet_start on the first options byte. The block takes one
// byte every cycle unless in_stall is high, and answers once per packet with
// found / malformed / absent, plus area, data offset and length when found. A
// byte is classified on the way in, waits in a four-entry queue, updates the
// walk register, and its result is registered in the output register; a
// stalled result holds the queue, which stalls the input once its four
// entries are full. The walk updates its state once per cycle unless stalled,
// which sets the rate at one byte per cycle. Write cfg_data to change the
// target code only while no packet is in flight.
module dhcp_option_locator #(
  parameter int unsigned OPTIONS_AREA_BYTES = dol_pkg::OPTIONS_AREA_BYTES_DEF,
  parameter int unsigned FILE_AREA_BYTES    = dol_pkg::FILE_AREA_BYTES_DEF,
  parameter int unsigned SNAME_AREA_BYTES   = dol_pkg::SNAME_AREA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_opt_byte,
  input  logic [1:0] in_area,
  input  logic       in_packet_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [1:0] out_found_area,
  output logic [8:0] out_data_offset,
  output logic [7:0] out_data_length
);

  dol_pkg::dol_req_t push_req;
  dol_pkg::dol_req_t pop_req;
  logic              pop_take;

  dol_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_opt_byte     (in_opt_byte),
    .in_area         (in_area),
    .in_packet_start (in_packet_start),
    .push_req        (push_req)
  );

  dol_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_req   (push_req),
    .push_stall (in_stall),
    .pop_req    (pop_req),
    .pop_take   (pop_take)
  );

  dol_back #(
    .OPTIONS_AREA_BYTES (OPTIONS_AREA_BYTES),
    .FILE_AREA_BYTES    (FILE_AREA_BYTES),
    .SNAME_AREA_BYTES   (SNAME_AREA_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_req         (pop_req),
    .pop_take        (pop_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_area  (out_found_area),
    .out_data_offset (out_data_offset),
    .out_data_length (out_data_length)
  );

endmodule

// ===== rtl/core/dol_front.sv =====
// ----------------------------------------------------------------------------
// dol_front
// Holds the target code register and classifies each accepted byte.
// ----------------------------------------------------------------------------
module dol_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  input  logic [7:0]        in_opt_byte,
  input  logic [1:0]        in_area,
  input  logic              in_packet_start,
  output dol_pkg::dol_req_t push_req
);

  logic [7:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= dol_pkg::TARGET_RESET;
    end else if (cfg_we) begin
      target_r <= cfg_data;
    end
  end

  always_comb begin
    push_req.valid                  = in_valid;
    push_req.item.opt_byte          = in_opt_byte;
    push_req.item.area              = in_area;
    push_req.item.packet_start      = in_packet_start;
    push_req.item.is_target         = (in_opt_byte == target_r);
    push_req.item.is_pad            = (in_opt_byte == dol_pkg::CODE_PAD);
    push_req.item.is_end            = (in_opt_byte == dol_pkg::CODE_END);
    push_req.item.is_overload       = (in_opt_byte == dol_pkg::CODE_OVERLOAD);
  end

endmodule

// ===== rtl/core/dol_queue.sv =====
// ----------------------------------------------------------------------------
// dol_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module dol_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dol_pkg::dol_req_t push_req,
  output logic              push_stall,
  output dol_pkg::dol_req_t pop_req,
  input  logic              pop_take
);

  dol_pkg::dol_item_t                mem_r [dol_pkg::QDEPTH];
  logic [dol_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [dol_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [dol_pkg::QCNT_W-1:0]        count_r;
  logic                              do_push;
  logic                              do_pop;

  assign push_stall = (count_r == dol_pkg::QCNT_W'(dol_pkg::QDEPTH));
  assign do_push    = push_req.valid && !push_stall;
  assign do_pop     = pop_take && (count_r != '0);

  assign pop_req.valid = (count_r != '0);
  assign pop_req.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/dol_back.sv =====
// ----------------------------------------------------------------------------
// dol_back
// Walks the options one byte per cycle unless stalled and registers the per-packet result.
// ----------------------------------------------------------------------------
module dol_back #(
  parameter int unsigned OPTIONS_AREA_BYTES = dol_pkg::OPTIONS_AREA_BYTES_DEF,
  parameter int unsigned FILE_AREA_BYTES    = dol_pkg::FILE_AREA_BYTES_DEF,
  parameter int unsigned SNAME_AREA_BYTES   = dol_pkg::SNAME_AREA_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dol_pkg::dol_req_t pop_req,
  output logic              pop_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [1:0]        out_found_area,
  output logic [8:0]        out_data_offset,
  output logic [7:0]        out_data_length
);

  localparam logic [dol_pkg::NOP_W-1:0] OPT_SIZE   = dol_pkg::NOP_W'(OPTIONS_AREA_BYTES);
  localparam logic [dol_pkg::NOP_W-1:0] FILE_SIZE  = dol_pkg::NOP_W'(FILE_AREA_BYTES);
  localparam logic [dol_pkg::NOP_W-1:0] SNAME_SIZE = dol_pkg::NOP_W'(SNAME_AREA_BYTES);

  // Walk state
  logic [1:0]                 area_r,    area_nxt;
  logic [dol_pkg::POS_W-1:0]  pos_r,     pos_nxt;
  logic [dol_pkg::NOP_W-1:0]  nop_r,     nop_nxt;
  dol_pkg::dol_phase_t        phase_r,   phase_nxt;
  logic                       cur_tgt_r, cur_tgt_nxt;
  logic                       cur_ovl_r, cur_ovl_nxt;
  logic [1:0]                 ovl_r,     ovl_nxt;
  logic                       ans_r,     ans_nxt;

  // State as seen by this byte, after a packet start clears it
  logic [1:0]                 e_area;
  logic [dol_pkg::POS_W-1:0]  e_pos;
  logic [dol_pkg::NOP_W-1:0]  e_nop;
  dol_pkg::dol_phase_t        e_phase;
  logic                       e_cur_tgt;
  logic                       e_cur_ovl;
  logic [1:0]                 e_ovl;
  logic                       e_ans;

  // Output register
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [1:0]                 out_found_area_r;
  logic [8:0]                 out_data_offset_r;
  logic [7:0]                 out_data_length_r;

  dol_pkg::dol_item_t         it;
  logic                       fire;
  logic                       active;
  logic [dol_pkg::NOP_W-1:0]  size;
  logic [dol_pkg::NOP_W-1:0]  pos_w;
  logic [dol_pkg::NOP_W-1:0]  pos_p1;
  logic [dol_pkg::NOP_W-1:0]  pos_b;
  logic [dol_pkg::NOP_W-1:0]  pos_p1_b;
  logic                       take_code;
  logic                       jump_file;
  logic                       jump_any;

  logic                       res_valid;
  logic [1:0]                 res_status;
  logic [1:0]                 res_area;
  logic [8:0]                 res_offset;
  logic [7:0]                 res_length;

  assign it       = pop_req.item;
  assign pop_take = !out_valid_r || !out_stall;
  assign fire     = pop_req.valid && pop_take;

  always_comb begin
    if (it.packet_start) begin
      e_area    = dol_pkg::AREA_OPTIONS;
      e_pos     = '0;
      e_nop     = '0;
      e_phase   = dol_pkg::PH_CODE;
      e_cur_tgt = 1'b0;
      e_cur_ovl = 1'b0;
      e_ovl     = 2'b00;
      e_ans     = 1'b0;
    end else begin
      e_area    = area_r;
      e_pos     = pos_r;
      e_nop     = nop_r;
      e_phase   = phase_r;
      e_cur_tgt = cur_tgt_r;
      e_cur_ovl = cur_ovl_r;
      e_ovl     = ovl_r;
      e_ans     = ans_r;
    end
  end

  always_comb begin
    case (e_area)
      dol_pkg::AREA_OPTIONS: size = OPT_SIZE;
      dol_pkg::AREA_FILE:    size = FILE_SIZE;
      default:               size = SNAME_SIZE;
    endcase
  end

  // Bytes of another area, or after the answer, pass through untouched
  assign active    = !e_ans && (it.area == e_area);
  assign pos_w     = dol_pkg::NOP_W'(e_pos);
  assign pos_p1    = pos_w + 1'b1;
  assign pos_b     = pos_w + dol_pkg::NOP_W'(it.opt_byte);
  assign pos_p1_b  = pos_p1 + dol_pkg::NOP_W'(it.opt_byte);
  // Target match wins over pad and end
  assign take_code = it.is_target || (!it.is_pad && !it.is_end);
  assign jump_file = (e_area == dol_pkg::AREA_OPTIONS) && e_ovl[0];
  assign jump_any  = jump_file || ((e_area != dol_pkg::AREA_SNAME) && e_ovl[1]);

  // Next state
  always_comb begin
    area_nxt    = e_area;
    pos_nxt     = e_pos;
    nop_nxt     = e_nop;
    phase_nxt   = e_phase;
    cur_tgt_nxt = e_cur_tgt;
    cur_ovl_nxt = e_cur_ovl;
    ovl_nxt     = e_ovl;
    ans_nxt     = e_ans;
    if (active) begin
      pos_nxt = e_pos + 1'b1;
      case (e_phase)
        dol_pkg::PH_CODE: begin
          if (take_code) begin
            cur_tgt_nxt = it.is_target;
            cur_ovl_nxt = it.is_overload;
            if (pos_p1 >= size) begin
              ans_nxt = 1'b1;
            end else begin
              phase_nxt = dol_pkg::PH_LEN;
            end
          end else if (it.is_pad) begin
            nop_nxt = pos_p1;
            if (pos_p1 >= size) begin
              ans_nxt = 1'b1;
            end
          end else if (jump_any) begin
            area_nxt  = jump_file ? dol_pkg::AREA_FILE : dol_pkg::AREA_SNAME;
            pos_nxt   = '0;
            nop_nxt   = '0;
            phase_nxt = dol_pkg::PH_CODE;
          end else begin
            ans_nxt = 1'b1;
          end
        end
        dol_pkg::PH_LEN: begin
          if (e_cur_tgt) begin
            ans_nxt = 1'b1;
          end else begin
            nop_nxt = pos_p1_b;
            if (pos_p1_b >= size) begin
              ans_nxt = 1'b1;
            end else if (it.opt_byte == 8'd0) begin
              if (e_cur_ovl) begin
                ovl_nxt = 2'b00;
              end
              phase_nxt = dol_pkg::PH_CODE;
            end else begin
              phase_nxt = e_cur_ovl ? dol_pkg::PH_OVER : dol_pkg::PH_DATA;
            end
          end
        end
        dol_pkg::PH_OVER: begin
          ovl_nxt   = it.opt_byte[1:0];
          phase_nxt = (pos_p1 >= e_nop) ? dol_pkg::PH_CODE : dol_pkg::PH_DATA;
        end
        default: begin
          if (pos_p1 >= e_nop) begin
            phase_nxt = dol_pkg::PH_CODE;
          end
        end
      endcase
    end
  end

  // Result of this byte
  always_comb begin
    res_valid  = 1'b0;
    res_status = dol_pkg::ST_ABSENT;
    res_area   = 2'b00;
    res_offset = '0;
    res_length = '0;
    if (active) begin
      case (e_phase)
        dol_pkg::PH_CODE: begin
          if (take_code || it.is_pad) begin
            if (pos_p1 >= size) begin
              res_valid  = 1'b1;
              res_status = dol_pkg::ST_BAD;
            end
          end else if (!jump_any) begin
            res_valid  = 1'b1;
            res_status = dol_pkg::ST_ABSENT;
          end
        end
        dol_pkg::PH_LEN: begin
          if (e_cur_tgt) begin
            res_valid = 1'b1;
            if (pos_b >= size) begin
              res_status = dol_pkg::ST_BAD;
            end else begin
              res_status = dol_pkg::ST_FOUND;
              res_area   = e_area;
              res_offset = pos_p1[8:0];
              res_length = it.opt_byte;
            end
          end else if (pos_p1_b >= size) begin
            res_valid  = 1'b1;
            res_status = dol_pkg::ST_BAD;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r    <= dol_pkg::AREA_OPTIONS;
      pos_r     <= '0;
      nop_r     <= '0;
      phase_r   <= dol_pkg::PH_CODE;
      cur_tgt_r <= 1'b0;
      cur_ovl_r <= 1'b0;
      ovl_r     <= 2'b00;
      ans_r     <= 1'b0;
    end else if (fire) begin
      area_r    <= area_nxt;
      pos_r     <= pos_nxt;
      nop_r     <= nop_nxt;
      phase_r   <= phase_nxt;
      cur_tgt_r <= cur_tgt_nxt;
      cur_ovl_r <= cur_ovl_nxt;
      ovl_r     <= ovl_nxt;
      ans_r     <= ans_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_status_r      <= res_status;
      out_found_area_r  <= res_area;
      out_data_offset_r <= res_offset;
      out_data_length_r <= res_length;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_area  = out_found_area_r;
  assign out_data_offset = out_data_offset_r;
  assign out_data_length = out_data_length_r;

  // A result always closes the packet
  a_answer_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid) |=> ans_r)
    else $error("result given without marking the packet answered");

  // No second result for the same packet
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ans_r && !(pop_req.valid && it.packet_start)) |-> !(fire && res_valid))
    else $error("second result within one packet");

  // The scan never leaves the three defined areas
  a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
    area_r != 2'd3)
    else $error("scan area out of range");

  // Only a found result carries location fields
  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != dol_pkg::ST_FOUND)) |->
      (out_found_area_r == 2'b00 && out_data_offset_r == '0 && out_data_length_r == '0))
    else $error("location fields set on a miss");

endmodule
